// ===== hdl/cpt_pkg.sv =====
// Shared constants, types and CORDIC step function for the Clarke/Park unit.
// Depends on nothing; used by every other file under hdl.
package cpt_pkg;

  // CORDIC layout: sixteen micro-rotations, two per register stage.
  localparam int CORDIC_STEPS    = 16;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int STEP_IDX_W      = $clog2(CORDIC_STEPS);
  // Reduction register, rotation stages, sign fix-up register.
  localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
  // Product register, sum register, saturation register.
  localparam int MAC_LAT         = 3;

  localparam int TURN_W    = 32;  // angle scaled to 32 bits per turn
  localparam int TRIG_W    = 32;  // sine, cosine and constants, Q2.30
  localparam int CW        = 34;  // CORDIC datapath, headroom over Q2.30
  localparam int FRAC_BITS = 30;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN    = 32'sd652032874;
  localparam logic signed [TRIG_W-1:0] INV_SQRT3_Q30  = 32'sd619925131;
  localparam logic signed [TRIG_W-1:0] SQRT3_HALF_Q30 = 32'sd929887698;
  localparam logic signed [TRIG_W-1:0] NEG_HALF_Q30   = -32'sd536870912;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cpt_vec_t;

  // Arctangent of 2^-i as a fraction of a turn, 32 bits per turn.
  function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
    logic signed [CW-1:0] val;
    case (idx)
      4'd0:    val = 34'sd536870912;
      4'd1:    val = 34'sd316933406;
      4'd2:    val = 34'sd167458908;
      4'd3:    val = 34'sd85004756;
      4'd4:    val = 34'sd42667334;
      4'd5:    val = 34'sd21354465;
      4'd6:    val = 34'sd10679839;
      4'd7:    val = 34'sd5340245;
      4'd8:    val = 34'sd2670163;
      4'd9:    val = 34'sd1335087;
      4'd10:   val = 34'sd667544;
      4'd11:   val = 34'sd333772;
      4'd12:   val = 34'sd166886;
      4'd13:   val = 34'sd83443;
      4'd14:   val = 34'sd41722;
      4'd15:   val = 34'sd20861;
      default: val = '0;
    endcase
    return val;
  endfunction

  // One micro-rotation: steer toward zero residual angle.
  function automatic cpt_vec_t cordic_step(input cpt_vec_t v,
                                           input logic [STEP_IDX_W-1:0] idx);
    cpt_vec_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = v.x >>> idx;
    ys = v.y >>> idx;
    if (!v.z[CW-1]) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_turn(idx);
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_turn(idx);
    end
    return r;
  endfunction

endpackage

// ===== hdl/cpt_mac.sv =====
// Pipelined two-product sum or difference with Q30 rounding and saturation.
// Depends on cpt_pkg for the fraction width.
module cpt_mac #(
  parameter int A_W      = 16,
  parameter int B_W      = 32,
  parameter int OUT_W    = 16,
  parameter bit SUBTRACT = 1'b0
) (
  input  logic                    clk,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  input  logic signed [A_W-1:0]   c,
  input  logic signed [B_W-1:0]   d,
  output logic signed [OUT_W-1:0] result
);
  import cpt_pkg::*;

  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_ab;
  logic signed [PROD_W-1:0] prod_cd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_shr;

  // Floor shift after adding half an LSB gives round-half-up.
  assign acc_shr = acc >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod_ab <= a * b;
    prod_cd <= c * d;
    if (SUBTRACT) begin
      acc <= ACC_W'(prod_ab) - ACC_W'(prod_cd) + ROUND_HALF;
    end else begin
      acc <= ACC_W'(prod_ab) + ACC_W'(prod_cd) + ROUND_HALF;
    end
    if (acc_shr > SAT_HI) begin
      result <= SAT_HI[OUT_W-1:0];
    end else if (acc_shr < SAT_LO) begin
      result <= SAT_LO[OUT_W-1:0];
    end else begin
      result <= acc_shr[OUT_W-1:0];
    end
  end

endmodule

// ===== hdl/cpt_cordic.sv =====
// Pipelined CORDIC sine/cosine generator, Q2.30 outputs.
// Depends on cpt_pkg for the step function, gain and stage layout.
module cpt_cordic #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic [ANGLE_WIDTH-1:0]           angle,
  output logic signed [cpt_pkg::TRIG_W-1:0] sin_val,
  output logic signed [cpt_pkg::TRIG_W-1:0] cos_val
);
  import cpt_pkg::*;

  logic [TURN_W-1:0] turn;
  logic [TURN_W-1:0] turn_red;
  logic              flip;

  cpt_vec_t vec [CORDIC_STAGES+1];
  cpt_vec_t vec_next [CORDIC_STAGES];
  logic     neg [CORDIC_STAGES+1];

  // Fold the second and third quarter turns by half a turn; negate at the end.
  assign turn     = {angle, {(TURN_W-ANGLE_WIDTH){1'b0}}};
  assign flip     = turn[TURN_W-1] ^ turn[TURN_W-2];
  assign turn_red = {turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]};

  always_comb begin
    cpt_vec_t t;
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      t = vec[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        t = cordic_step(t, STEP_IDX_W'(s * STEPS_PER_STAGE + k));
      end
      vec_next[s] = t;
    end
  end

  always_ff @(posedge clk) begin
    vec[0].x <= CW'(CORDIC_GAIN);
    vec[0].y <= '0;
    vec[0].z <= CW'($signed(turn_red));
    neg[0]   <= flip;
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      vec[s+1] <= vec_next[s];
      neg[s+1] <= neg[s];
    end
    if (neg[CORDIC_STAGES]) begin
      sin_val <= TRIG_W'(-vec[CORDIC_STAGES].y);
      cos_val <= TRIG_W'(-vec[CORDIC_STAGES].x);
    end else begin
      sin_val <= TRIG_W'(vec[CORDIC_STAGES].y);
      cos_val <= TRIG_W'(vec[CORDIC_STAGES].x);
    end
  end

endmodule

// ===== hdl/clarke_park_transform_unit.sv =====
// Top level of the Clarke/Park transform unit for field-oriented control.
// Depends on cpt_pkg, cpt_cordic and cpt_mac.
//
// Channel   Direction  Transfer when       Payload
// ------------------------------------------------------------------------------
// command   in         start && !busy      cur_u/v/w, elec_angle, volt_d/q_cmd
// result    out        done (one cycle)    cur_alpha/beta/d/q, volt_alpha/beta/u/v/w
//
// Pipeline: a fully pipelined datapath takes one transfer every clock cycle;
//   busy stays low. The command is registered at its transfer edge in the input
//   register, then passes the CORDIC (reduction register, eight stages of two
//   micro-rotations, sign fix-up register), two rounds of product, sum and
//   saturation registers, and the output register, loaded together with done.
//   The CORDIC depth and the two MAC rounds set the latency.
// Reset clears only the valid bits; data registers run free.
// Stalls: none; the receiver must take every result in its done cycle.
module clarke_park_transform_unit #(
  parameter int SIGNAL_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SIGNAL_WIDTH-1:0] cur_u,
  input  logic signed [SIGNAL_WIDTH-1:0] cur_v,
  input  logic signed [SIGNAL_WIDTH-1:0] cur_w,
  input  logic [ANGLE_WIDTH-1:0]         elec_angle,
  input  logic signed [SIGNAL_WIDTH-1:0] volt_d_cmd,
  input  logic signed [SIGNAL_WIDTH-1:0] volt_q_cmd,
  output logic                           done,
  output logic signed [SIGNAL_WIDTH-1:0] cur_alpha,
  output logic signed [SIGNAL_WIDTH-1:0] cur_beta,
  output logic signed [SIGNAL_WIDTH-1:0] cur_d,
  output logic signed [SIGNAL_WIDTH-1:0] cur_q,
  output logic signed [SIGNAL_WIDTH-1:0] volt_alpha,
  output logic signed [SIGNAL_WIDTH-1:0] volt_beta,
  output logic signed [SIGNAL_WIDTH-1:0] volt_u,
  output logic signed [SIGNAL_WIDTH-1:0] volt_v,
  output logic signed [SIGNAL_WIDTH-1:0] volt_w
);
  import cpt_pkg::*;

  // Stage offsets counted from the input register.
  localparam int PARK_AT  = CORDIC_LAT;             // sine/cosine ready
  localparam int PIPE_LAT = CORDIC_LAT + 2 * MAC_LAT;
  localparam int IB_LEN   = PIPE_LAT - MAC_LAT;

  // Input register.
  logic                           in_vld;
  logic signed [SIGNAL_WIDTH-1:0] iu;
  logic signed [SIGNAL_WIDTH-1:0] iv;
  logic signed [SIGNAL_WIDTH-1:0] iw;
  logic [ANGLE_WIDTH-1:0]         ang;
  logic signed [SIGNAL_WIDTH-1:0] vd;
  logic signed [SIGNAL_WIDTH-1:0] vq;

  // Delay lines that keep side data aligned with the CORDIC and MAC stages.
  logic                           vld_dly [PIPE_LAT];
  logic signed [SIGNAL_WIDTH-1:0] iu_dly  [PIPE_LAT];
  logic signed [SIGNAL_WIDTH-1:0] vd_dly  [PARK_AT];
  logic signed [SIGNAL_WIDTH-1:0] vq_dly  [PARK_AT];
  logic signed [SIGNAL_WIDTH-1:0] ib_dly  [IB_LEN];
  logic signed [SIGNAL_WIDTH-1:0] id_dly  [MAC_LAT];
  logic signed [SIGNAL_WIDTH-1:0] iq_dly  [MAC_LAT];
  logic signed [SIGNAL_WIDTH-1:0] va_dly  [MAC_LAT];
  logic signed [SIGNAL_WIDTH-1:0] vb_dly  [MAC_LAT];

  logic signed [SIGNAL_WIDTH:0]   iv_minus_iw;
  logic signed [TRIG_W-1:0]       sin_q30;
  logic signed [TRIG_W-1:0]       cos_q30;
  logic signed [SIGNAL_WIDTH-1:0] ib_raw;
  logic signed [SIGNAL_WIDTH-1:0] ia_park;
  logic signed [SIGNAL_WIDTH-1:0] ib_park;
  logic signed [SIGNAL_WIDTH-1:0] id_raw;
  logic signed [SIGNAL_WIDTH-1:0] iq_raw;
  logic signed [SIGNAL_WIDTH-1:0] va_raw;
  logic signed [SIGNAL_WIDTH-1:0] vb_raw;
  logic signed [SIGNAL_WIDTH-1:0] vv_raw;
  logic signed [SIGNAL_WIDTH-1:0] vw_raw;

  // The pipeline never backs up, so a transfer is taken every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
      for (int k = 0; k < PIPE_LAT; k++) begin
        vld_dly[k] <= 1'b0;
      end
    end else begin
      in_vld     <= start;
      vld_dly[0] <= in_vld;
      for (int k = 1; k < PIPE_LAT; k++) begin
        vld_dly[k] <= vld_dly[k-1];
      end
      done <= vld_dly[PIPE_LAT-1];
    end
  end

  // Capture the command and advance the side data; payload needs no reset.
  always_ff @(posedge clk) begin
    iu  <= cur_u;
    iv  <= cur_v;
    iw  <= cur_w;
    ang <= elec_angle;
    vd  <= volt_d_cmd;
    vq  <= volt_q_cmd;

    iu_dly[0] <= iu;
    for (int k = 1; k < PIPE_LAT; k++) begin
      iu_dly[k] <= iu_dly[k-1];
    end
    vd_dly[0] <= vd;
    vq_dly[0] <= vq;
    for (int k = 1; k < PARK_AT; k++) begin
      vd_dly[k] <= vd_dly[k-1];
      vq_dly[k] <= vq_dly[k-1];
    end
    ib_dly[0] <= ib_raw;
    for (int k = 1; k < IB_LEN; k++) begin
      ib_dly[k] <= ib_dly[k-1];
    end
    id_dly[0] <= id_raw;
    iq_dly[0] <= iq_raw;
    va_dly[0] <= va_raw;
    vb_dly[0] <= vb_raw;
    for (int k = 1; k < MAC_LAT; k++) begin
      id_dly[k] <= id_dly[k-1];
      iq_dly[k] <= iq_dly[k-1];
      va_dly[k] <= va_dly[k-1];
      vb_dly[k] <= vb_dly[k-1];
    end

    // Output register: hold each result for its single done cycle.
    cur_alpha  <= iu_dly[PIPE_LAT-1];
    cur_beta   <= ib_dly[IB_LEN-1];
    cur_d      <= id_dly[MAC_LAT-1];
    cur_q      <= iq_dly[MAC_LAT-1];
    volt_alpha <= va_dly[MAC_LAT-1];
    volt_beta  <= vb_dly[MAC_LAT-1];
    volt_u     <= va_dly[MAC_LAT-1];
    volt_v     <= vv_raw;
    volt_w     <= vw_raw;
  end

  // Sine and cosine of the electrical angle.
  cpt_cordic #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_cordic (
    .clk    (clk),
    .angle  (ang),
    .sin_val(sin_q30),
    .cos_val(cos_q30)
  );

  // Clarke beta: (V - W) / sqrt(3), runs alongside the CORDIC.
  assign iv_minus_iw = (SIGNAL_WIDTH+1)'(iv) - (SIGNAL_WIDTH+1)'(iw);

  cpt_mac #(
    .A_W(SIGNAL_WIDTH + 1), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b0)
  ) u_clarke_beta (
    .clk(clk), .a(iv_minus_iw), .b(INV_SQRT3_Q30), .c('0), .d('0), .result(ib_raw)
  );

  // Park rotation on the alpha current and the saturated beta current.
  assign ia_park = iu_dly[PARK_AT-1];
  assign ib_park = ib_dly[PARK_AT-MAC_LAT-1];

  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b0)
  ) u_park_d (
    .clk(clk), .a(ia_park), .b(cos_q30), .c(ib_park), .d(sin_q30), .result(id_raw)
  );

  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b1)
  ) u_park_q (
    .clk(clk), .a(ib_park), .b(cos_q30), .c(ia_park), .d(sin_q30), .result(iq_raw)
  );

  // Inverse Park rotation on the voltage command.
  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b1)
  ) u_ipark_alpha (
    .clk(clk), .a(vd_dly[PARK_AT-1]), .b(cos_q30), .c(vq_dly[PARK_AT-1]), .d(sin_q30),
    .result(va_raw)
  );

  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b0)
  ) u_ipark_beta (
    .clk(clk), .a(vq_dly[PARK_AT-1]), .b(cos_q30), .c(vd_dly[PARK_AT-1]), .d(sin_q30),
    .result(vb_raw)
  );

  // Inverse Clarke on the saturated alpha/beta voltages; U is alpha itself.
  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b0)
  ) u_iclarke_v (
    .clk(clk), .a(va_raw), .b(NEG_HALF_Q30), .c(vb_raw), .d(SQRT3_HALF_Q30),
    .result(vv_raw)
  );

  cpt_mac #(
    .A_W(SIGNAL_WIDTH), .B_W(TRIG_W), .OUT_W(SIGNAL_WIDTH), .SUBTRACT(1'b1)
  ) u_iclarke_w (
    .clk(clk), .a(va_raw), .b(NEG_HALF_Q30), .c(vb_raw), .d(SQRT3_HALF_Q30),
    .result(vw_raw)
  );

endmodule
